// File: src/pgd_pkg.sv
`timescale 1ns / 1ps

package pgd_pkg;

   localparam int HALF_W    = 64;
   localparam int BYTE_W    = 8;
   localparam int LANES     = HALF_W / BYTE_W;
   localparam int RSP_DATA_W = 256;

   localparam int KIND_W    = 6;
   localparam int REALM_W   = 13;
   localparam int MAP_W     = 13;
   localparam int ENTRY_W   = 23;
   localparam int SUB_W     = 6;
   localparam int SERVER_W  = 24;
   localparam int COUNTER_W = 40;

   localparam int KIND_LSB   = 58;
   localparam int REALM_LSB  = 42;
   localparam int MAP_LSB    = 29;
   localparam int ENTRY_LSB  = 6;
   localparam int SERVER_LSB = 40;

   typedef struct packed {
      logic [HALF_W-1:0] high_half;
      logic [HALF_W-1:0] low_half;
   } halves_type;

   typedef struct packed {
      logic                 is_empty;
      logic [COUNTER_W-1:0] counter_value;
      logic [SERVER_W-1:0]  server_number;
      logic [SUB_W-1:0]     sub_kind;
      logic [ENTRY_W-1:0]   entry_number;
      logic [MAP_W-1:0]     map_number;
      logic [REALM_W-1:0]   realm_number;
      logic [KIND_W-1:0]    kind_code;
      logic [HALF_W-1:0]    low_half;
      logic [HALF_W-1:0]    high_half;
   } fields_type;

endpackage

// File: src/pgd_fields.sv
`timescale 1ns / 1ps

module pgd_fields (
   input  pgd_pkg::halves_type halves,
   output pgd_pkg::fields_type fields
);
   import pgd_pkg::*;

   logic [HALF_W-1:0] hi;
   logic [HALF_W-1:0] lo;

   assign hi = halves.high_half;
   assign lo = halves.low_half;

   always_comb begin
      fields.high_half     = hi;
      fields.low_half      = lo;
      fields.kind_code     = hi[KIND_LSB +: KIND_W];
      fields.realm_number  = hi[REALM_LSB +: REALM_W];
      fields.map_number    = hi[MAP_LSB +: MAP_W];
      fields.entry_number  = hi[ENTRY_LSB +: ENTRY_W];
      fields.sub_kind      = hi[SUB_W-1:0];
      fields.server_number = lo[SERVER_LSB +: SERVER_W];
      fields.counter_value = lo[COUNTER_W-1:0];
      fields.is_empty      = (hi == '0) && (lo == '0);
   end

endmodule

// File: src/packed_guid128_decoder_unit.sv
`timescale 1ns / 1ps
// The byte completing an identifier loads the result register (skid if it is held).
// Throughput: one byte per cycle while skid is empty, set by the byte-lane insert.
// A two-deep output (result register plus skid register) keeps input flowing while
// a result waits. Synchronous active-high reset returns to expecting a low mask,
// clears the pending masks and accumulators and empties the output.
module packed_guid128_decoder_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] stream_byte
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [pgd_pkg::RSP_DATA_W-1:0]  rsp_tdata    // [63:0] high_half,
   // [127:64] low_half, [133:128] kind_code, [146:134] realm_number,
   // [159:147] map_number, [182:160] entry_number, [188:183] sub_kind,
   // [212:189] server_number, [252:213] counter_value, [253] is_empty, [255:254] zero
);
   import pgd_pkg::*;

   localparam logic [1:0] PH_LOW_MASK  = 2'd0;
   localparam logic [1:0] PH_HIGH_MASK = 2'd1;
   localparam logic [1:0] PH_DATA      = 2'd2;

   logic [1:0]        phase_ff, phase_in;
   logic [LANES-1:0]  low_pend_ff, low_pend_in;
   logic [LANES-1:0]  high_pend_ff, high_pend_in;
   logic [HALF_W-1:0] low_acc_ff, low_acc_in;
   logic [HALF_W-1:0] high_acc_ff, high_acc_in;

   halves_type out_ff, out_in;
   logic       out_valid_ff, out_valid_in;
   halves_type skid_ff, skid_in;
   logic       skid_valid_ff, skid_valid_in;

   logic [BYTE_W-1:0] in_byte;
   logic              accept;
   logic              take;
   logic              done;
   logic              emit_now;
   logic [LANES-1:0]  pend_sel;
   logic [LANES-1:0]  lane_sel;
   fields_type        fields;

   assign in_byte    = req_tdata;
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign take       = out_valid_ff && rsp_tready;
   assign emit_now   = accept && done;

   always_comb begin
      phase_in     = phase_ff;
      low_pend_in  = low_pend_ff;
      high_pend_in = high_pend_ff;
      low_acc_in   = low_acc_ff;
      high_acc_in  = high_acc_ff;
      done         = 1'b0;
      pend_sel     = (low_pend_ff != '0) ? low_pend_ff : high_pend_ff;
      // isolate the lowest pending lane
      lane_sel     = pend_sel & (~pend_sel + LANES'(1));
      case (phase_ff)
         PH_HIGH_MASK: begin
            high_pend_in = in_byte;
            if (low_pend_ff == '0 && in_byte == '0) begin
               done     = 1'b1;
               phase_in = PH_LOW_MASK;
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            for (int k = 0; k < LANES; k++) begin
               if (lane_sel[k]) begin
                  if (low_pend_ff != '0) begin
                     low_acc_in[k*BYTE_W +: BYTE_W] = low_acc_ff[k*BYTE_W +: BYTE_W] | in_byte;
                  end else begin
                     high_acc_in[k*BYTE_W +: BYTE_W] =
                        high_acc_ff[k*BYTE_W +: BYTE_W] | in_byte;
                  end
               end
            end
            if (low_pend_ff != '0) begin
               low_pend_in = low_pend_ff & ~lane_sel;
            end else begin
               high_pend_in = high_pend_ff & ~lane_sel;
            end
            if (low_pend_in == '0 && high_pend_in == '0) begin
               done     = 1'b1;
               phase_in = PH_LOW_MASK;
            end
         end
         default: begin
            low_pend_in  = in_byte;
            high_pend_in = '0;
            low_acc_in   = '0;
            high_acc_in  = '0;
            phase_in     = PH_HIGH_MASK;
         end
      endcase
   end

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in.high_half = high_acc_in;
            out_in.low_half  = low_acc_in;
            out_valid_in     = emit_now;
         end
      end else if (emit_now) begin
         // hold the new result until the output register frees up
         skid_in.high_half = high_acc_in;
         skid_in.low_half  = low_acc_in;
         skid_valid_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LOW_MASK;
         low_pend_ff   <= '0;
         high_pend_ff  <= '0;
         low_acc_ff    <= '0;
         high_acc_ff   <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff     <= phase_in;
            low_pend_ff  <= low_pend_in;
            high_pend_ff <= high_pend_in;
            low_acc_ff   <= low_acc_in;
            high_acc_ff  <= high_acc_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   pgd_fields u_fields (
      .halves (out_ff),
      .fields (fields)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, fields};

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a result while output register is empty");

   a_emit_returns: assert property (@(posedge clock) disable iff (reset)
      emit_now |=> (phase_ff == PH_LOW_MASK && low_pend_ff == '0 && high_pend_ff == '0))
      else $error("state not back to low mask after result");

   a_data_pending: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (low_pend_ff != '0 || high_pend_ff != '0))
      else $error("collecting data with nothing pending");

   a_emit_lands: assert property (@(posedge clock) disable iff (reset)
      emit_now |=> (out_valid_ff && (skid_valid_ff || !$past(out_valid_ff && !rsp_tready))))
      else $error("result lost between accept and output");

endmodule
